FILE: sv/awi_pkg.sv
// ----------------------------------------------------------------------------
// awi_pkg - shared constants for the averaged waveform interpolator
// Field widths, register indexes, reset values and default step count.
// ----------------------------------------------------------------------------
package awi_pkg;

   // default number of interpolated points per sample
   localparam int STEPS_DEFAULT = 10;

   // field widths
   localparam int SUM_W    = 32;
   localparam int COUNT_W  = 16;
   localparam int OFFSET_W = 24;
   localparam int CODE_W   = 24;

   // configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] REG_AVERAGE_COUNT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_OFFSET_LEVEL  = 1'd1;

   // register reset values
   localparam logic [COUNT_W-1:0]  AVERAGE_COUNT_RESET = 16'd1;
   localparam logic [OFFSET_W-1:0] OFFSET_LEVEL_RESET  = 24'd524288;

   // end marker word
   localparam logic [CODE_W-1:0] MARKER_CODE = {CODE_W{1'b1}};

endpackage

FILE: sv/awi_divider.sv
// ----------------------------------------------------------------------------
// awi_divider - iterative unsigned divider
// Restoring division, one quotient bit per cycle over the DIVIDEND_W bits of
// the dividend. Quotient holds after done until the next start.
// ----------------------------------------------------------------------------
module awi_divider #(
   parameter int DIVIDEND_W = 44,
   parameter int DIVISOR_W  = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_W - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;

   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    trial_sub;
   logic                  fits;

   // one restoring step
   always_comb begin
      trial     = {rem_ff, quo_ff[DIVIDEND_W-1]};
      trial_sub = trial - {1'b0, divisor_ff};
      fits      = (trial >= {1'b0, divisor_ff});
   end

   // next state
   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quo_in     = quo_ff;
      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         rem_in     = '0;
         divisor_in = divisor;
         quo_in     = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quo_ff     <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: sv/averaged_waveform_interpolator_unit.sv
// ----------------------------------------------------------------------------
// averaged_waveform_interpolator_unit - x STEPS linear upsampler of sums
// Divides accumulated sums by the averaging count and emits interpolated,
// offset-corrected, inverted 24-bit points followed by an end marker.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one accumulated sum per transfer in tdata, tlast marks the
//   final sample of a buffer. rsp_* carries one point per transfer: tdata is
//   the 24-bit code, tuser flags the all-ones end marker, tlast marks the
//   final result caused by one input. csr_* writes average_count (index 0)
//   and offset_level (index 1); write only while the block is idle.
//   A first sample that is not final produces nothing; each later sample
//   releases STEPS points of the previous one. The final sample adds STEPS
//   flat points and the end marker.
//   Every point goes through one shared restoring divider, one quotient bit
//   a cycle over 40+clog2(STEPS+1) bits; DMUL and YMUL set up each sample,
//   XMUL and DIFF each point, and EMIT hands it off. req_tready is high
//   only while the sequencer is idle.
//   A stalled receiver holds the sequencer before it loads the output
//   register; nothing is dropped. Reset clears the held sample, restores the
//   register defaults and empties the output register.
// ----------------------------------------------------------------------------
module averaged_waveform_interpolator_unit #(
   parameter int STEPS = awi_pkg::STEPS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // input stream; tdata: sum_value[31:0]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [awi_pkg::SUM_W-1:0]        req_tdata,
   // tlast: last_sample
   input  logic                             req_tlast,
   // result stream; tdata: sample_code[23:0]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [awi_pkg::CODE_W-1:0]       rsp_tdata,
   // tuser: end_marker
   output logic                             rsp_tuser,
   output logic                             rsp_tlast,
   // configuration write port
   input  logic                             csr_we,
   input  logic [awi_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [awi_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int SUM_W   = awi_pkg::SUM_W;
   localparam int COUNT_W = awi_pkg::COUNT_W;
   localparam int OFF_W   = awi_pkg::OFFSET_W;
   localparam int CODE_W  = awi_pkg::CODE_W;
   localparam int J_W     = $clog2(STEPS + 1);
   localparam int P_W     = SUM_W + J_W;
   localparam int D_W     = COUNT_W + J_W;
   localparam int Y_W     = OFF_W + D_W;

   localparam logic [J_W-1:0] STEPS_J  = J_W'(STEPS);
   localparam logic [J_W-1:0] J_LAST   = J_W'(STEPS - 1);

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DMUL = 3'd1;
   localparam logic [2:0] ST_YMUL = 3'd2;
   localparam logic [2:0] ST_XMUL = 3'd3;
   localparam logic [2:0] ST_DIFF = 3'd4;
   localparam logic [2:0] ST_DIV  = 3'd5;
   localparam logic [2:0] ST_EMIT = 3'd6;
   localparam logic [2:0] ST_MARK = 3'd7;

   logic [2:0]         state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [OFF_W-1:0]   offset_ff, offset_in;
   logic [SUM_W-1:0]   prev_ff, prev_in;
   logic               have_prev_ff, have_prev_in;
   logic [SUM_W-1:0]   a_ff, a_in;
   logic [SUM_W-1:0]   cur_ff, cur_in;
   logic               fin_ff, fin_in;
   logic               flat_ff, flat_in;
   logic [J_W-1:0]     j_ff, j_in;
   logic [D_W-1:0]     d_ff, d_in;
   logic [Y_W-1:0]     y_ff, y_in;
   logic [P_W-1:0]     p_ff, p_in;
   logic               neg_ff, neg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]  rsp_code_ff, rsp_code_in;
   logic               rsp_user_ff, rsp_user_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [COUNT_W-1:0] count_eff;
   logic [Y_W-1:0]     x_ext;
   logic               x_ge_y;
   logic [Y_W-1:0]     div_dividend;
   logic               div_start;
   logic               div_done;
   logic [Y_W-1:0]     div_quotient;
   logic [CODE_W-1:0]  q_low;
   logic [CODE_W-1:0]  point_code;
   logic               out_free;
   logic               req_transfer;

   // shared divider for all points
   awi_divider #(
      .DIVIDEND_W (Y_W),
      .DIVISOR_W  (D_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (d_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // point arithmetic around the divider
   always_comb begin
      count_eff    = (count_ff == '0) ? COUNT_W'(1) : count_ff;
      x_ext        = Y_W'({p_ff, 4'b0000});
      x_ge_y       = (x_ext >= y_ff);
      div_dividend = x_ge_y ? (x_ext - y_ff) : (y_ff - x_ext);
      div_start    = (state_ff == ST_DIFF);
      q_low        = div_quotient[CODE_W-1:0];
      point_code   = neg_ff ? q_low : (CODE_W'(0) - q_low);
      out_free     = !rsp_valid_ff || rsp_tready;
      req_transfer = req_tvalid && (state_ff == ST_IDLE);
   end

   // sequencer and register next values
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      offset_in    = offset_ff;
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      a_in         = a_ff;
      cur_in       = cur_ff;
      fin_in       = fin_ff;
      flat_in      = flat_ff;
      j_in         = j_ff;
      d_in         = d_ff;
      y_in         = y_ff;
      p_in         = p_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_code_in  = rsp_code_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;

      // configuration writes
      if (csr_we) begin
         case (csr_index)
            awi_pkg::REG_AVERAGE_COUNT: count_in  = csr_wdata[COUNT_W-1:0];
            awi_pkg::REG_OFFSET_LEVEL:  offset_in = csr_wdata[OFF_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_transfer) begin
               cur_in  = req_tdata;
               fin_in  = req_tlast;
               a_in    = have_prev_ff ? prev_ff : req_tdata;
               flat_in = !have_prev_ff;
               j_in    = '0;
               if (have_prev_ff || req_tlast) begin
                  state_in = ST_DMUL;
               end
               if (req_tlast) begin
                  prev_in      = '0;
                  have_prev_in = 1'b0;
               end else begin
                  prev_in      = req_tdata;
                  have_prev_in = 1'b1;
               end
            end
         end
         ST_DMUL: begin
            d_in     = D_W'(count_eff) * D_W'(STEPS_J);
            state_in = ST_YMUL;
         end
         ST_YMUL: begin
            y_in     = Y_W'(offset_ff) * Y_W'(d_ff);
            state_in = ST_XMUL;
         end
         ST_XMUL: begin
            p_in     = P_W'(a_ff) * P_W'(STEPS_J - j_ff) + P_W'(cur_ff) * P_W'(j_ff);
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            neg_in   = !x_ge_y;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = point_code;
               rsp_user_in  = 1'b0;
               rsp_last_in  = !flat_ff && !fin_ff && (j_ff == J_LAST);
               if (j_ff == J_LAST) begin
                  j_in = '0;
                  if (flat_ff) begin
                     state_in = ST_MARK;
                  end else if (fin_ff) begin
                     flat_in  = 1'b1;
                     a_in     = cur_ff;
                     state_in = ST_XMUL;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = ST_XMUL;
               end
            end
         end
         ST_MARK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = awi_pkg::MARKER_CODE;
               rsp_user_in  = 1'b1;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= awi_pkg::AVERAGE_COUNT_RESET;
         offset_ff    <= awi_pkg::OFFSET_LEVEL_RESET;
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         offset_ff    <= offset_in;
         prev_ff      <= prev_in;
         have_prev_ff <= have_prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      cur_ff      <= cur_in;
      fin_ff      <= fin_in;
      flat_ff     <= flat_in;
      j_ff        <= j_in;
      d_ff        <= d_in;
      y_ff        <= y_in;
      p_ff        <= p_in;
      neg_ff      <= neg_in;
      rsp_code_ff <= rsp_code_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_code_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: verif/tb_averaged_waveform_interpolator_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_averaged_waveform_interpolator_unit - stream check of the x10 upsampler
// Feeds buffers of accumulated sums under several count and offset settings,
// predicts every interpolated point and end marker in exact integer math,
// and compares each result transfer field by field in arrival order.
// Both sides idle at random, and the receiver holds off once for a long time.
// ----------------------------------------------------------------------------
module tb_averaged_waveform_interpolator_unit;

   localparam int STEPS       = awi_pkg::STEPS_DEFAULT;
   localparam int SUM_W       = awi_pkg::SUM_W;
   localparam int CODE_W      = awi_pkg::CODE_W;
   localparam int COUNT_W     = awi_pkg::COUNT_W;
   localparam int OFFSET_W    = awi_pkg::OFFSET_W;
   localparam int CSR_INDEX_W = awi_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W  = awi_pkg::CSR_DATA_W;
   // two sequencer passes of one sample, STEPS points each
   localparam int ITEM_CYCLES = 2 + 2 * STEPS * 48 + 40;
   localparam int LONG_HOLD   = 4000;

   typedef struct packed {
      logic [SUM_W-1:0] sum_value;
      logic             last_sample;
   } sample_type;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              marker;
      logic              is_last;
   } point_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [SUM_W-1:0]       req_tdata  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [CODE_W-1:0]      rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   // stimulus and expectation stores
   sample_type pending_items[$];
   point_type  expected_points[$];

   // predictor state and register copies
   logic [COUNT_W-1:0]  count_setting  = awi_pkg::AVERAGE_COUNT_RESET;
   logic [OFFSET_W-1:0] offset_setting = awi_pkg::OFFSET_LEVEL_RESET;
   logic [SUM_W-1:0]    held_sum       = '0;
   logic                have_held      = 1'b0;

   int  samples_offered = 0;
   int  samples_taken   = 0;
   int  send_gap        = 0;
   int  recv_gap        = 0;
   int  hold_left       = 0;
   int  error_count     = 0;
   bit  idling_on       = 1'b1;
   bit  long_hold_due   = 1'b0;
   bit  long_hold_done  = 1'b0;

   averaged_waveform_interpolator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // one interpolated point: negated, offset-corrected, wrapped to 24 bits
   function automatic logic [CODE_W-1:0] point_code(input logic [SUM_W-1:0] from_sum,
                                                    input logic [SUM_W-1:0] to_sum,
                                                    input int step);
      logic [63:0] divisor;
      logic [63:0] scaled;
      logic [63:0] baseline;
      logic [63:0] quotient;
      divisor  = 64'(STEPS) * ((count_setting == '0) ? 64'd1 : 64'(count_setting));
      scaled   = 64'd16 * (64'(from_sum) * 64'(STEPS - step) + 64'(to_sum) * 64'(step));
      baseline = 64'(offset_setting) * divisor;
      if (scaled >= baseline) begin
         quotient = (scaled - baseline) / divisor;
         return CODE_W'(0) - quotient[CODE_W-1:0];
      end
      quotient = (baseline - scaled) / divisor;
      return quotient[CODE_W-1:0];
   endfunction

   // expected points released by one accepted sample
   task automatic predict_sample(input logic [SUM_W-1:0] sum_value, input logic last_sample);
      int first_new;
      first_new = expected_points.size();
      if (have_held) begin
         for (int j = 0; j < STEPS; j++)
            expected_points.push_back('{point_code(held_sum, sum_value, j), 1'b0, 1'b0});
      end
      if (last_sample) begin
         for (int j = 0; j < STEPS; j++)
            expected_points.push_back('{point_code(sum_value, sum_value, j), 1'b0, 1'b0});
         expected_points.push_back('{awi_pkg::MARKER_CODE, 1'b1, 1'b0});
         held_sum  = '0;
         have_held = 1'b0;
      end else begin
         held_sum  = sum_value;
         have_held = 1'b1;
      end
      if (expected_points.size() > first_new)
         expected_points[expected_points.size() - 1].is_last = 1'b1;
   endtask

   // sender: next sum offered at the falling edge once the last one was taken
   always @(negedge clock) begin : sender
      sample_type next_item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || samples_taken == samples_offered) begin
         if (send_gap > 0) begin
            send_gap = send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            next_item = pending_items.pop_front();
            req_tdata  <= next_item.sum_value;
            req_tlast  <= next_item.last_sample;
            req_tvalid <= 1'b1;
            samples_offered = samples_offered + 1;
            if (idling_on && $urandom_range(0, 3) == 0)
               send_gap = $urandom_range(1, 12);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // input transfers feed the predictor
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         predict_sample(req_tdata, req_tlast);
         samples_taken = samples_taken + 1;
      end
   end

   // receiver: random stall bursts plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (long_hold_due && !long_hold_done) begin
            hold_left      = LONG_HOLD;
            long_hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap = recv_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (idling_on && $urandom_range(0, 4) == 0)
               recv_gap = $urandom_range(1, 12);
         end
      end
   end

   // result transfers against the oldest expectation
   always @(posedge clock) begin : result_check
      point_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected result code %h marker %b last %b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            error_count = error_count + 1;
         end else begin
            want = expected_points.pop_front();
            if (rsp_tdata !== want.code || rsp_tuser !== want.marker
                || rsp_tlast !== want.is_last) begin
               $display("%0t: expected code %h marker %b last %b, got code %h marker %b last %b",
                        $time, want.code, want.marker, want.is_last,
                        rsp_tdata, rsp_tuser, rsp_tlast);
               error_count = error_count + 1;
            end
         end
      end
   end

   // register write at the falling edge, mirrored into the predictor
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (index == awi_pkg::REG_AVERAGE_COUNT)
         count_setting = value[COUNT_W-1:0];
      else if (index == awi_pkg::REG_OFFSET_LEVEL)
         offset_setting = value[OFFSET_W-1:0];
   endtask

   // count goes in the low bits; the unused upper bits carry junk
   task automatic set_levels(input logic [COUNT_W-1:0] count, input logic [OFFSET_W-1:0] offset);
      write_register(awi_pkg::REG_AVERAGE_COUNT, {8'($urandom), count});
      write_register(awi_pkg::REG_OFFSET_LEVEL, offset);
   endtask

   // all sums taken, all points seen, then room for a silent sample in flight
   task automatic wait_idle();
      while (pending_items.size() > 0 || samples_taken != samples_offered
             || expected_points.size() > 0)
         @(negedge clock);
      repeat (ITEM_CYCLES) @(negedge clock);
   endtask

   // sums near the zero crossing of the corrected value are favored
   function automatic logic [SUM_W-1:0] random_sum();
      logic [63:0] crossing;
      crossing = 64'(offset_setting) * ((count_setting == '0) ? 64'd1 : 64'(count_setting)) / 16;
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return $urandom;
         default: begin
            crossing = crossing + 64'($urandom_range(0, 4000)) - 64'd2000;
            if (crossing[63])
               return '0;
            if (crossing > 64'hFFFF_FFFF)
               return '1;
            return crossing[SUM_W-1:0];
         end
      endcase
   endfunction

   // mostly whole buffers, now and then a stray sample
   task automatic queue_random(input int total);
      int queued;
      int len;
      queued = 0;
      while (queued < total) begin
         if ($urandom_range(0, 7) == 0) begin
            pending_items.push_back('{random_sum(), 1'($urandom)});
            queued = queued + 1;
         end else begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
               pending_items.push_back('{random_sum(), k == len - 1});
            queued = queued + len;
         end
      end
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // reset settings: single-sample buffers, extremes, zero crossing
      pending_items.push_back('{32'h0000_0000, 1'b1});
      pending_items.push_back('{32'hFFFF_FFFF, 1'b1});
      pending_items.push_back('{32'd32768, 1'b0});
      pending_items.push_back('{32'd32769, 1'b0});
      pending_items.push_back('{32'h0000_0000, 1'b0});
      pending_items.push_back('{32'hFFFF_FFFF, 1'b0});
      pending_items.push_back('{32'h8000_0000, 1'b1});
      wait_idle();

      // zero count acts as one, no offset
      set_levels(16'd0, 24'd0);
      pending_items.push_back('{32'hFFFF_FFFF, 1'b0});
      pending_items.push_back('{32'h0000_0000, 1'b0});
      pending_items.push_back('{32'h0000_0001, 1'b1});
      pending_items.push_back('{32'h5555_AAAA, 1'b1});
      wait_idle();

      // largest count and offset
      set_levels(16'hFFFF, 24'hFF_FFFF);
      pending_items.push_back('{32'hFFFF_FFFF, 1'b0});
      pending_items.push_back('{32'h0000_0000, 1'b1});
      pending_items.push_back('{32'h1234_5678, 1'b1});
      wait_idle();

      // count one with the largest offset
      set_levels(16'd1, 24'hFF_FFFF);
      pending_items.push_back('{32'hFFFF_FFFF, 1'b0});
      pending_items.push_back('{32'hAAAA_5555, 1'b1});
      wait_idle();

      // random phases, long receiver hold-off in the first
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       set_levels(16'd1, awi_pkg::OFFSET_LEVEL_RESET);
            1:       set_levels(16'hFFFF, 24'($urandom));
            2:       set_levels(16'($urandom_range(1, 300)), 24'($urandom));
            default: set_levels(16'($urandom_range(1, 65535)), 24'd0);
         endcase
         queue_random(65);
         if (phase == 0)
            long_hold_due = 1'b1;
         wait_idle();
      end

      // last stretch without any idling
      idling_on = 1'b0;
      set_levels(16'($urandom_range(1, 1000)), 24'($urandom));
      queue_random(35);
      wait_idle();

      if (error_count == 0 && expected_points.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

FILE: averaged_waveform_interpolator_unit.f
sv/awi_pkg.sv
sv/awi_divider.sv
sv/averaged_waveform_interpolator_unit.sv
verif/tb_averaged_waveform_interpolator_unit.sv
